[design/interval_merge_table_macros.svh]
// Assertion macros shared by the checker of interval_merge_table.
// Needs a clock named clk and a reset named rst in the using scope.
`ifndef INTERVAL_MERGE_TABLE_MACROS_SVH
`define INTERVAL_MERGE_TABLE_MACROS_SVH

// implication checked at every rising edge outside reset
`define IMT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication whose consequent is checked in the next cycle
`define IMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/imt_pkg.sv]
// Shared types and codes of the interval merge table.
// No dependencies.
package imt_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MERGE,
    S_FIX,
    S_QCALC,
    S_RES
  } state_t;

  typedef enum logic [1:0] {
    CC_HOLD,
    CC_SHL,
    CC_SHR,
    CC_FIX
  } cell_cmd_t;

  // broadcast to every cell
  typedef struct packed {
    cell_cmd_t cmd;
    logic      incl;  // below means hi <= key rather than hi < key
  } cell_ctrl_t;

endpackage

[design/imt_req_if.sv]
// Request channel of the interval merge table: valid/ready plus payload.
// No dependencies.
interface imt_req_if #(parameter int PAGE_BITS = 48) ();
  logic                 valid;
  logic                 ready;
  logic                 op;
  logic [PAGE_BITS-1:0] first_page;
  logic [PAGE_BITS-1:0] end_page;
  logic [PAGE_BITS-1:0] query_page;

  modport source (output valid, op, first_page, end_page, query_page, input ready);
  modport sink   (input valid, op, first_page, end_page, query_page, output ready);
endinterface

[design/imt_rsp_if.sv]
// Response channel of the interval merge table: valid/ready plus payload.
// No dependencies.
interface imt_rsp_if #(parameter int PAGE_BITS = 48, parameter int COUNT_BITS = 7) ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [COUNT_BITS-1:0] range_count;
  logic [PAGE_BITS:0]    total_pages;
  logic [PAGE_BITS:0]    compact_offset;

  modport source (output valid, status, range_count, total_pages, compact_offset,
                  input ready);
  modport sink   (input valid, status, range_count, total_pages, compact_offset,
                  output ready);
endinterface

[design/interval_merge_table.sv]
// Interval merge table: sorted union of half-open page ranges with rank queries.
// Channels: req (op, first_page, end_page, query_page) and rsp (status,
// range_count, total_pages, compact_offset), both valid/ready; a transaction
// happens when valid and ready are high at a rising edge.
// One item is worked on at a time; req.ready is high only when the engine idles.
// Query: chain compare on acceptance, then offset add, then the result is registered.
// Insert: each held range that it absorbs is removed by one left shift of the
// cell chain, the new range placed by one right shift, then a fix step updates
// the prefix lengths of later cells.
// Empty or inverted range, or full table: table unchanged.
// Next req can be accepted in the cycle after the result is registered.
// The result sits in an output register; while rsp is stalled a new item may be
// accepted and worked on, and its result waits until the register frees.
// Reset (rst, synchronous) empties the table; range storage is not cleared.
// Depends on imt_pkg, imt_req_if, imt_rsp_if and imt_cell.
module interval_merge_table import imt_pkg::*; #(
  parameter int MAX_RANGES = 64,
  parameter int PAGE_BITS  = 48
) (
  input  logic        clk,
  input  logic        rst,
  imt_req_if.sink     req,
  imt_rsp_if.source   rsp
);

  localparam int CW = $clog2(MAX_RANGES + 1);
  localparam int PW = PAGE_BITS;

  state_t state, state_next;

  logic [CW-1:0] count, count_next;
  logic [PW:0]   covered, covered_next;
  logic [PW:0]   del, del_next;
  logic [PW:0]   base_pre, base_pre_next;
  logic [PW-1:0] mlo, mlo_next, mhi, mhi_next;
  logic          absorbed, absorbed_next;
  logic [PW-1:0] q, q_next, q_lo, q_lo_next;
  logic [PW:0]   q_pre, q_pre_next;
  logic          q_found, q_found_next;
  status_t       res_status, res_status_next;
  logic [PW:0]   res_off, res_off_next;

  cell_ctrl_t    ctrl;
  logic [PW-1:0] key;
  logic [PW-1:0] inj_lo, inj_hi;
  logic [PW:0]   inj_pre;

  logic          c_valid [MAX_RANGES];
  logic [PW-1:0] c_lo    [MAX_RANGES];
  logic [PW-1:0] c_hi    [MAX_RANGES];
  logic [PW:0]   c_pre   [MAX_RANGES];
  logic          c_below [MAX_RANGES];
  logic          c_first [MAX_RANGES];

  logic          sel_valid;
  logic [PW-1:0] sel_lo, sel_hi;
  logic [PW:0]   sel_pre;

  for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
    logic          pb, pv, nv;
    logic [PW-1:0] plo, phi, nlo, nhi;
    logic [PW:0]   ppre, npre;
    if (i == 0) begin : g_head
      assign pb = 1'b1;  assign pv = 1'b0;
      assign plo = '0;   assign phi = '0;  assign ppre = '0;
    end else begin : g_mid
      assign pb = c_below[i-1];  assign pv = c_valid[i-1];
      assign plo = c_lo[i-1];    assign phi = c_hi[i-1];  assign ppre = c_pre[i-1];
    end
    if (i == MAX_RANGES - 1) begin : g_tail
      assign nv = 1'b0;
      assign nlo = '0;  assign nhi = '0;  assign npre = '0;
    end else begin : g_body
      assign nv = c_valid[i+1];
      assign nlo = c_lo[i+1];  assign nhi = c_hi[i+1];  assign npre = c_pre[i+1];
    end
    imt_cell #(.PAGE_BITS(PW)) u_cell (
      .clk, .rst, .ctrl, .key, .inj_lo, .inj_hi, .inj_pre, .del,
      .prev_below(pb), .prev_valid(pv), .prev_lo(plo), .prev_hi(phi), .prev_pre(ppre),
      .next_valid(nv), .next_lo(nlo), .next_hi(nhi), .next_pre(npre),
      .valid(c_valid[i]), .lo(c_lo[i]), .hi(c_hi[i]), .pre(c_pre[i]),
      .below(c_below[i]), .first(c_first[i])
    );
  end

  // one-hot pick of the first cell not below the key
  always_comb begin
    sel_valid = 1'b0;
    sel_lo    = '0;
    sel_hi    = '0;
    sel_pre   = '0;
    for (int i = 0; i < MAX_RANGES; i++) begin
      sel_valid = sel_valid | (c_first[i] & c_valid[i]);
      sel_lo    = sel_lo  | ({PW{c_first[i]}} & c_lo[i]);
      sel_hi    = sel_hi  | ({PW{c_first[i]}} & c_hi[i]);
      sel_pre   = sel_pre | ({(PW+1){c_first[i]}} & c_pre[i]);
    end
  end

  logic [PW:0] sel_len, new_len, pre_now, q_part;
  logic        touch, out_free;

  always_comb begin
    sel_len  = {1'b0, sel_hi} - {1'b0, sel_lo};
    new_len  = {1'b0, mhi} - {1'b0, mlo};
    pre_now  = sel_valid ? sel_pre : covered;
    touch    = sel_valid && (sel_lo <= mhi);
    q_part   = (q > q_lo) ? ({1'b0, q} - {1'b0, q_lo}) : '0;
    out_free = !rsp.valid || rsp.ready;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    covered_next    = covered;
    del_next        = del;
    base_pre_next   = base_pre;
    mlo_next        = mlo;
    mhi_next        = mhi;
    absorbed_next   = absorbed;
    q_next          = q;
    q_lo_next       = q_lo;
    q_pre_next      = q_pre;
    q_found_next    = q_found;
    res_status_next = res_status;
    res_off_next    = res_off;
    ctrl            = '{cmd: CC_HOLD, incl: 1'b0};
    key             = mlo;
    inj_lo          = mlo;
    inj_hi          = mhi;
    inj_pre         = absorbed ? base_pre : pre_now;
    req.ready       = 1'b0;

    unique case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        key       = req.query_page;
        ctrl.incl = 1'b1;
        if (req.valid) begin
          if (req.op == OP_QUERY) begin
            q_next       = req.query_page;
            q_found_next = sel_valid;
            q_lo_next    = sel_lo;
            q_pre_next   = sel_pre;
            state_next   = S_QCALC;
          end else if (req.end_page <= req.first_page) begin
            res_status_next = ST_EMPTY;
            res_off_next    = '0;
            state_next      = S_RES;
          end else begin
            mlo_next      = req.first_page;
            mhi_next      = req.end_page;
            absorbed_next = 1'b0;
            del_next      = '0;
            state_next    = S_MERGE;
          end
        end
      end
      S_MERGE: begin
        if (!absorbed) base_pre_next = pre_now;
        if (touch) begin
          ctrl.cmd      = CC_SHL;
          mlo_next      = (sel_lo < mlo) ? sel_lo : mlo;
          mhi_next      = (sel_hi > mhi) ? sel_hi : mhi;
          covered_next  = covered - sel_len;
          del_next      = del - sel_len;
          count_next    = count - CW'(1);
          absorbed_next = 1'b1;
        end else if (!absorbed && count == CW'(MAX_RANGES)) begin
          res_status_next = ST_FULL;
          res_off_next    = '0;
          state_next      = S_RES;
        end else begin
          ctrl.cmd     = CC_SHR;
          covered_next = covered + new_len;
          del_next     = del + new_len;
          count_next   = count + CW'(1);
          state_next   = S_FIX;
        end
      end
      S_FIX: begin
        // later cells pick up the net change in length before them
        key             = mhi;
        ctrl.cmd        = CC_FIX;
        res_status_next = ST_OK;
        res_off_next    = '0;
        state_next      = S_RES;
      end
      S_QCALC: begin
        res_status_next = ST_OK;
        res_off_next    = q_found ? (q_pre + q_part) : covered;
        state_next      = S_RES;
      end
      S_RES: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      covered   <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      covered <= covered_next;
      if (state == S_RES && out_free) rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    del        <= del_next;
    base_pre   <= base_pre_next;
    mlo        <= mlo_next;
    mhi        <= mhi_next;
    absorbed   <= absorbed_next;
    q          <= q_next;
    q_lo       <= q_lo_next;
    q_pre      <= q_pre_next;
    q_found    <= q_found_next;
    res_status <= res_status_next;
    res_off    <= res_off_next;
    if (state == S_RES && out_free) begin
      rsp.status         <= res_status;
      rsp.range_count    <= count;
      rsp.total_pages    <= covered;
      rsp.compact_offset <= res_off;
    end
  end

endmodule

[design/imt_cell.sv]
// One slot of the sorted range chain: bounds, prefix length and valid bit.
// Depends on imt_pkg; neighbours feed it through the shift ports.
module imt_cell import imt_pkg::*; #(
  parameter int PAGE_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cell_ctrl_t           ctrl,
  input  logic [PAGE_BITS-1:0] key,
  input  logic [PAGE_BITS-1:0] inj_lo,
  input  logic [PAGE_BITS-1:0] inj_hi,
  input  logic [PAGE_BITS:0]   inj_pre,
  input  logic [PAGE_BITS:0]   del,
  input  logic                 prev_below,
  input  logic                 prev_valid,
  input  logic [PAGE_BITS-1:0] prev_lo,
  input  logic [PAGE_BITS-1:0] prev_hi,
  input  logic [PAGE_BITS:0]   prev_pre,
  input  logic                 next_valid,
  input  logic [PAGE_BITS-1:0] next_lo,
  input  logic [PAGE_BITS-1:0] next_hi,
  input  logic [PAGE_BITS:0]   next_pre,
  output logic                 valid,
  output logic [PAGE_BITS-1:0] lo,
  output logic [PAGE_BITS-1:0] hi,
  output logic [PAGE_BITS:0]   pre,
  output logic                 below,
  output logic                 first
);

  // table is sorted, so below cells form a prefix of the chain
  always_comb begin
    below = valid && (ctrl.incl ? (hi <= key) : (hi < key));
    first = !below && prev_below;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      unique case (ctrl.cmd)
        CC_SHL: if (!below) valid <= next_valid;
        CC_SHR: begin
          if (first) valid <= 1'b1;
          else if (!below) valid <= prev_valid;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.cmd)
      CC_SHL: begin
        if (!below) begin
          lo  <= next_lo;
          hi  <= next_hi;
          pre <= next_pre;
        end
      end
      CC_SHR: begin
        if (first) begin
          lo  <= inj_lo;
          hi  <= inj_hi;
          pre <= inj_pre;
        end else if (!below) begin
          lo  <= prev_lo;
          hi  <= prev_hi;
          pre <= prev_pre;
        end
      end
      CC_FIX: if (valid && lo > key) pre <= pre + del;
      default: ;
    endcase
  end

endmodule

[design/imt_checker.sv]
// Port-level checks of interval_merge_table, bound to the top level.
// Depends on imt_pkg and interval_merge_table_macros.svh.
`include "interval_merge_table_macros.svh"

module imt_checker import imt_pkg::*; #(
  parameter int MAX_RANGES = 64,
  parameter int CW         = 7
) (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_ready,
  input logic [1:0]    status,
  input logic [CW-1:0] range_count
);

  `IMT_ASSERT_NEXT(a_rsp_hold, out_valid && !out_ready, out_valid && $stable(status), "rsp dropped or changed while stalled")
  `IMT_ASSERT_IMPL(a_count_max, out_valid, range_count <= CW'(MAX_RANGES), "range count beyond capacity")
  `IMT_ASSERT_IMPL(a_status_code, out_valid, status == ST_OK || status == ST_FULL || status == ST_EMPTY, "undefined status")
  `IMT_ASSERT_IMPL(a_full_count, out_valid && status == ST_FULL, range_count == CW'(MAX_RANGES), "full reported below capacity")

endmodule

bind interval_merge_table imt_checker #(
  .MAX_RANGES(MAX_RANGES),
  .CW($clog2(MAX_RANGES + 1))
) u_imt_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(rsp.valid),
  .out_ready(rsp.ready),
  .status(rsp.status),
  .range_count(rsp.range_count)
);
